// ===== hw/rtl/packet_loss_drop_decision_assert.svh =====
// Assertion macros for the drop decision RTL.
// Expects signals named clk and arst_n in the module that uses them.
`ifndef PACKET_LOSS_DROP_DECISION_ASSERT_SVH
`define PACKET_LOSS_DROP_DECISION_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLD_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pld: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PLD_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pld: next-cycle check failed");

`endif

// ===== hw/rtl/pld_pkg.sv =====
// Package for the packet drop decision block: widths, constants, types.
// No dependencies; the interfaces, divider, datapath, controller and top level import it.
`default_nettype none

package pld_pkg;

	localparam int ADDR_W            = 48;
	localparam int PCT_W             = 7;
	localparam int RND_W             = 15;
	localparam int ROLL_W            = 14;
	localparam int NUM_W             = 19;
	localparam int DEN_W             = 7;
	localparam int TABLE_ENTRIES_DEF = 64;

	localparam int PROB_BASIS    = 10000;
	localparam int EXIT_BAD_PROB = 5000;
	localparam int PERCENT_FULL  = 100;

	localparam logic MODE_BERNOULLI = 1'b0;
	localparam logic MODE_GILBERT   = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic clear_step;
		logic load;
		logic run;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic div_done;
		logic scan_done;
		logic out_free;
	} dp_stat_t;

	typedef struct packed {
		logic              valid;
		logic              bad;
		logic [ADDR_W-1:0] addr;
	} entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pld_in_if.sv =====
// Packet channel: valid/ready handshake carrying one packet descriptor.
// Depends on pld_pkg for field widths.
`default_nettype none

interface pld_in_if;
	import pld_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] sender_address;
	logic [PCT_W-1:0]  loss_percent;
	logic [RND_W-1:0]  random_word;

	modport source (output valid, output sender_address, output loss_percent,
		output random_word, input ready);
	modport sink (input valid, input sender_address, input loss_percent,
		input random_word, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pld_out_if.sv =====
// Verdict channel: valid/ready handshake carrying drop and table_full.
// Depends on pld_pkg only by convention.
`default_nettype none

interface pld_out_if;
	import pld_pkg::*;

	logic valid;
	logic ready;
	logic drop;
	logic table_full;

	modport source (output valid, output drop, output table_full, input ready);
	modport sink (input valid, input drop, input table_full, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pld_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire                                     clk,
	input  wire                                     we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                         wdata,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

`default_nettype wire

// ===== hw/rtl/pld_div.sv =====
// Restoring divider, one quotient bit per step.
// Depends on pld_pkg for operand widths.
`default_nettype none

module pld_div (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire                      step,
	input  wire [pld_pkg::NUM_W-1:0] num,
	input  wire [pld_pkg::DEN_W-1:0] den,
	output logic                     done,
	output logic [pld_pkg::NUM_W-1:0] quo
);
	import pld_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};
	assign done  = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (step && !done) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Quotient bits shift into the numerator register as it drains.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (step && !done) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign quo = num_q;
endmodule

`default_nettype wire

// ===== hw/rtl/pld_datapath.sv =====
// Datapath: mode register, packet capture, divider, sender table scan,
// verdict logic and output register. Depends on pld_pkg, pld_div, pld_ram.
`default_nettype none

module pld_datapath #(
	parameter int TABLE_ENTRIES = pld_pkg::TABLE_ENTRIES_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire                       cfg_wdata,
	input  wire [pld_pkg::ADDR_W-1:0] sender_address,
	input  wire [pld_pkg::PCT_W-1:0]  loss_percent,
	input  wire [pld_pkg::RND_W-1:0]  random_word,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic                      drop,
	output logic                      table_full,
	input  pld_pkg::ctrl_cmd_t        cmd,
	output pld_pkg::dp_stat_t         status
);
	import pld_pkg::*;

	localparam int IDX_W       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(TABLE_ENTRIES + 1);
	localparam int ENT_W       = $bits(entry_t);
	localparam int RECIP_100   = 5243;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W      = ROLL_W + 13;

	// Configuration and captured packet
	logic              loss_mode_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PCT_W-1:0]  pct_q;
	logic [ROLL_W-1:0] roll_q;

	// Incoming packet preprocessing
	logic [PCT_W-1:0]  pct_sat;
	logic [ROLL_W-1:0] roll_in;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;

	// Divider
	logic              div_done;
	logic [NUM_W-1:0]  div_quo;

	// Bernoulli remainder by 100
	logic [PROD_W-1:0] bern_prod;
	logic [PCT_W-1:0]  bern_quo;
	logic [PCT_W-1:0]  bern_rem;

	// Table scan
	logic [CNT_W-1:0]  scan_cnt_q;
	logic              chk_vld_s1;
	logic [IDX_W-1:0]  scan_idx_s1;
	logic              match_q;
	logic              match_bad_q;
	logic [IDX_W-1:0]  match_idx_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [IDX_W-1:0]  clr_cnt_q;
	logic              issue;
	logic              scan_end;
	logic              see_match;
	logic              see_free;
	logic [ENT_W-1:0]  ram_rdata;
	entry_t            rd_entry;

	// Verdict and write-back
	logic              pct_zero;
	logic              pct_full;
	logic              enter_hit;
	logic              exit_hit;
	logic              drop_d;
	logic              full_d;
	logic              tbl_we;
	logic [IDX_W-1:0]  tbl_idx;
	entry_t            tbl_entry;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	entry_t            ram_wentry;

	// Output register
	logic              out_valid_q;
	logic              drop_q;
	logic              full_q;

	// Saturate percent, reduce the random word mod 10000 by constant compares.
	always_comb begin
		pct_sat = (loss_percent > PCT_W'(PERCENT_FULL)) ? PCT_W'(PERCENT_FULL)
			: loss_percent;
		if (random_word >= RND_W'(3 * PROB_BASIS)) begin
			roll_in = ROLL_W'(random_word - RND_W'(3 * PROB_BASIS));
		end else if (random_word >= RND_W'(2 * PROB_BASIS)) begin
			roll_in = ROLL_W'(random_word - RND_W'(2 * PROB_BASIS));
		end else if (random_word >= RND_W'(PROB_BASIS)) begin
			roll_in = ROLL_W'(random_word - RND_W'(PROB_BASIS));
		end else begin
			roll_in = ROLL_W'(random_word);
		end
		// Gilbert-Elliott enter-bad ratio: percent*5000 / (100 - percent).
		div_num = NUM_W'(pct_sat) * NUM_W'(EXIT_BAD_PROB);
		div_den = DEN_W'(PERCENT_FULL) - pct_sat;
	end

	pld_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.load),
		.step   (cmd.run),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign issue     = cmd.run && (scan_cnt_q != CNT_W'(TABLE_ENTRIES));
	assign scan_end  = (scan_cnt_q == CNT_W'(TABLE_ENTRIES)) && !chk_vld_s1;
	assign rd_entry  = entry_t'(ram_rdata);
	assign see_match = chk_vld_s1 && rd_entry.valid && (rd_entry.addr == addr_q) && !match_q;
	assign see_free  = chk_vld_s1 && !rd_entry.valid && !free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_mode_q <= MODE_BERNOULLI;
			scan_cnt_q  <= '0;
			chk_vld_s1  <= 1'b0;
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				loss_mode_q <= cfg_wdata;
			end
			if (cmd.clear_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			chk_vld_s1 <= issue;
			if (cmd.load) begin
				scan_cnt_q <= '0;
				match_q    <= 1'b0;
				free_q     <= 1'b0;
			end else begin
				if (issue) begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
				end
				if (see_match) begin
					match_q <= 1'b1;
				end
				if (see_free) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: the read index of each check is the issue index delayed by one register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= sender_address;
			pct_q  <= pct_sat;
			roll_q <= roll_in;
		end
		if (see_match) begin
			match_idx_q <= scan_idx_s1;
			match_bad_q <= rd_entry.bad;
		end
		if (see_free) begin
			free_idx_q <= scan_idx_s1;
		end
		if (cmd.commit) begin
			drop_q <= drop_d;
			full_q <= full_d;
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_cnt_q[IDX_W-1:0];
	end

	// Bernoulli: the roll is the word mod 10000, so roll mod 100 is the word mod 100.
	// Quotient by reciprocal multiplication, exact for rolls below 10000.
	always_comb begin
		bern_prod = PROD_W'(roll_q) * PROD_W'(RECIP_100);
		bern_quo  = bern_prod[RECIP_SHIFT +: PCT_W];
		bern_rem  = PCT_W'(roll_q - ROLL_W'(bern_quo) * ROLL_W'(PERCENT_FULL));
	end

	// Verdict. Enter-bad threshold is max(1, quotient), or certain at 100 percent.
	always_comb begin
		pct_zero  = (pct_q == '0);
		pct_full  = (pct_q == PCT_W'(PERCENT_FULL));
		enter_hit = pct_full || (roll_q == '0) || (NUM_W'(roll_q) < div_quo);
		exit_hit  = roll_q < ROLL_W'(EXIT_BAD_PROB);
		drop_d    = 1'b0;
		full_d    = 1'b0;
		tbl_we    = 1'b0;
		tbl_idx   = match_idx_q;
		tbl_entry = '{valid: 1'b1, bad: 1'b0, addr: addr_q};
		if (loss_mode_q == MODE_BERNOULLI) begin
			drop_d = !pct_zero && (pct_full || (bern_rem < pct_q));
		end else if (pct_zero) begin
			// Free the sender's slot.
			tbl_we    = match_q;
			tbl_entry = '0;
		end else if (match_q) begin
			tbl_we = 1'b1;
			if (match_bad_q) begin
				drop_d        = 1'b1;
				tbl_entry.bad = !exit_hit;
			end else begin
				drop_d        = enter_hit;
				tbl_entry.bad = enter_hit;
			end
		end else if (free_q) begin
			tbl_we        = 1'b1;
			tbl_idx       = free_idx_q;
			drop_d        = enter_hit;
			tbl_entry.bad = enter_hit;
		end else begin
			drop_d = enter_hit;
			full_d = 1'b1;
		end
	end

	always_comb begin
		ram_we     = cmd.clear_step || (cmd.commit && tbl_we);
		ram_waddr  = cmd.clear_step ? clr_cnt_q : tbl_idx;
		ram_wentry = cmd.clear_step ? entry_t'('0) : tbl_entry;
	end

	pld_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wentry),
		.raddr (scan_cnt_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign status.clear_last = (clr_cnt_q == IDX_W'(TABLE_ENTRIES - 1));
	assign status.div_done   = div_done;
	assign status.scan_done  = scan_end || (loss_mode_q == MODE_BERNOULLI);
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign drop       = drop_q;
	assign table_full = full_q;
endmodule

`default_nettype wire

// ===== hw/rtl/pld_ctrl.sv =====
// Controller state machine: clearing pass, accept, run, commit.
// Depends on pld_pkg and the assertion macro header.
`default_nettype none
`include "packet_loss_drop_decision_assert.svh"

module pld_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  pld_pkg::dp_stat_t  status,
	output pld_pkg::ctrl_cmd_t cmd
);
	import pld_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (status.div_done && status.scan_done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_RUN: begin
				cmd.run = 1'b1;
			end
			ST_FINISH: begin
				cmd.commit = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`PLD_ASSERT_NXT(a_load_runs, cmd.load, state_q == ST_RUN)
	`PLD_ASSERT_IMP(a_run_ends_done, (state_q == ST_RUN) && (state_d != ST_RUN),
		status.div_done && status.scan_done)
	`PLD_ASSERT_NXT(a_commit_idle, cmd.commit, (state_q == ST_IDLE) && in_ready)
	`PLD_ASSERT_NXT(a_stall_holds, (state_q == ST_FINISH) && !status.out_free,
		state_q == ST_FINISH)
endmodule

`default_nettype wire

// ===== hw/rtl/packet_loss_drop_decision.sv =====
// Packet drop decision block: Bernoulli or Gilbert-Elliott burst loss per sender.
// Top level; depends on pld_pkg, pld_in_if, pld_out_if, pld_ctrl, pld_datapath.
//
// Usage:
//   pkt      - sink channel; one transaction is one packet (sender_address,
//              loss_percent, random_word). Accepted on valid & ready.
//   verdict  - source channel; one transaction per packet with drop and
//              table_full, in packet order.
//   cfg_we / cfg_wdata - write loss_mode (0 Bernoulli, 1 Gilbert-Elliott);
//              write only while no packet is in flight.
// Timing: after acceptance the run phase lasts, in Gilbert-Elliott mode, until both the
//   divider steps and a one-entry-per-cycle scan of the sender table RAM with registered
//   read are done, and in Bernoulli mode until the divider is done; then the commit state
//   registers the verdict. A new packet is taken only after the previous one has committed.
// Reset: arst_n clears control state and the mode register, then a clearing
//   pass writes zero to every table entry; pkt.ready stays low meanwhile.
// Backpressure: the verdict sits in an output register, so a new packet is
//   accepted and processed while the previous verdict waits; a finished
//   packet holds in commit until the output register frees up.
`default_nettype none

module packet_loss_drop_decision #(
	parameter int TABLE_ENTRIES = pld_pkg::TABLE_ENTRIES_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       cfg_we,
	input  wire       cfg_wdata,
	pld_in_if.sink    pkt,
	pld_out_if.source verdict
);
	import pld_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  status;

	// Controller: sequences the clearing pass and each packet transaction.
	pld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pkt.valid),
		.in_ready (pkt.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: divider, table scan and update, verdict register.
	pld_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.sender_address (pkt.sender_address),
		.loss_percent   (pkt.loss_percent),
		.random_word    (pkt.random_word),
		.out_valid      (verdict.valid),
		.out_ready      (verdict.ready),
		.drop           (verdict.drop),
		.table_full     (verdict.table_full),
		.cmd            (cmd),
		.status         (status)
	);
endmodule

`default_nettype wire
